[rtl/i2ra_pkg.sv]
// i2ra_pkg: shared types, codes and character constants for the integer
// to radix ASCII converter. Used by every module in rtl/.
`timescale 1ns / 1ps

package i2ra_pkg;

  // Default configuration
  localparam int DEF_MAX_DIGIT_SLOTS = 24;
  localparam int DEF_VALUE_WIDTH     = 64;
  localparam int QUEUE_DEPTH         = 2;

  // Format commands on the input tuser
  localparam logic [2:0] CMD_UDEC = 3'd0;
  localparam logic [2:0] CMD_SDEC = 3'd1;
  localparam logic [2:0] CMD_OCT  = 3'd2;
  localparam logic [2:0] CMD_HEXL = 3'd3;
  localparam logic [2:0] CMD_HEXU = 3'd4;

  // ASCII characters
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_NUL     = 8'h00;

  // Radix class of a queued item
  typedef enum logic [1:0] {
    FMT_DEC,
    FMT_OCT,
    FMT_HEX
  } fmt_t;

  // Classified item control, travels through the queue beside the magnitude
  typedef struct packed {
    fmt_t       fmt;
    logic       upper;
    logic       neg;
    logic [7:0] budget;
  } item_ctl_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DABBLE,
    ST_SPLIT,
    ST_SIGN,
    ST_DIGITS,
    ST_NUL,
    ST_EMPTY
  } back_state_t;

  // One digit value to its ASCII character
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? CH_UPPER_A : CH_LOWER_A;
    if (d < 4'd10) begin
      return CH_ZERO + 8'(d);
    end
    return base + 8'(d) - 8'd10;
  endfunction

endpackage

[rtl/integer_to_radix_ascii.sv]
// integer_to_radix_ascii: top level; front classifier, item queue and
// conversion back end. Depends on i2ra_pkg, i2ra_front, i2ra_queue, i2ra_back.
`timescale 1ns / 1ps
// Usage
//   Input stream (s_*): one transfer per operand. tdata carries the value
//   and the character budget, tuser the format command; codes above hex
//   upper act as unsigned decimal.
//   Output stream (m_*): one transfer per character, most significant
//   digit first, optional '-' ahead and a NUL behind when room is left.
//   tuser flags a written character; a zero budget gives a single transfer
//   with the flag low. tlast marks the final transfer of each operand and
//   every transfer carries the untruncated length.
// Timing
//   The front takes an operand per cycle until the two-entry queue fills.
//   The back handles one operand at a time: it fetches it from the queue,
//   runs double dabble for decimal, splits the digits into the digit store
//   and then emits the output transfers, most significant digit first.
// Reset and stalls
//   rst empties the queue and output register. A stalled receiver holds
//   the output register; the back end waits, the queue then fills and
//   s_tready drops.
module integer_to_radix_ascii #(
  parameter int VALUE_WIDTH     = i2ra_pkg::DEF_VALUE_WIDTH,
  parameter int MAX_DIGIT_SLOTS = i2ra_pkg::DEF_MAX_DIGIT_SLOTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // value [63:0], max_chars [71:64]
  input  logic [2:0]  s_tuser,   // command [2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // char_code [7:0], full_length [12:8], zero pad
  output logic [0:0]  m_tuser,   // char_valid [0]
  output logic        m_tlast
);

  localparam int CTL_W = $bits(i2ra_pkg::item_ctl_t);
  localparam int Q_W   = CTL_W + VALUE_WIDTH;

  i2ra_pkg::item_ctl_t    push_ctl;
  logic [VALUE_WIDTH-1:0] push_mag;
  logic                   push;
  logic                   q_full;
  logic                   q_pop;
  logic                   q_valid;
  logic [Q_W-1:0]         q_head;
  i2ra_pkg::item_ctl_t    head_ctl;
  logic [VALUE_WIDTH-1:0] head_mag;

  // Accept and classify
  i2ra_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (push),
    .q_ctl    (push_ctl),
    .q_mag    (push_mag)
  );

  // Decoupling queue
  i2ra_queue #(
    .WIDTH (Q_W),
    .DEPTH (i2ra_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_ctl, push_mag}),
    .pop       (q_pop),
    .head_data (q_head),
    .not_empty (q_valid),
    .full      (q_full)
  );

  assign head_ctl = q_head[Q_W-1 -: CTL_W];
  assign head_mag = q_head[VALUE_WIDTH-1:0];

  // Convert and emit
  i2ra_back #(
    .VALUE_WIDTH     (VALUE_WIDTH),
    .MAX_DIGIT_SLOTS (MAX_DIGIT_SLOTS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ctl    (head_ctl),
    .q_mag    (head_mag),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

[rtl/i2ra_front.sv]
// i2ra_front: accepts input transfers, decodes the format command and
// takes the magnitude of signed operands. Depends on i2ra_pkg.
`timescale 1ns / 1ps

module i2ra_front #(
  parameter int VALUE_WIDTH = i2ra_pkg::DEF_VALUE_WIDTH
) (
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [71:0]                 s_tdata,   // value [63:0], max_chars [71:64]
  input  logic [2:0]                  s_tuser,   // command [2:0]
  input  logic                        q_full,
  output logic                        q_push,
  output i2ra_pkg::item_ctl_t         q_ctl,
  output logic [VALUE_WIDTH-1:0]      q_mag
);

  logic [VALUE_WIDTH-1:0] operand;
  logic                   neg;

  assign operand  = s_tdata[VALUE_WIDTH-1:0];
  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  // Command decode; unknown codes behave as unsigned decimal
  always_comb begin
    q_ctl.upper  = 1'b0;
    q_ctl.budget = s_tdata[71:64];
    neg          = 1'b0;
    unique case (s_tuser) inside
      i2ra_pkg::CMD_SDEC: begin
        q_ctl.fmt = i2ra_pkg::FMT_DEC;
        neg       = operand[VALUE_WIDTH-1];
      end
      i2ra_pkg::CMD_OCT: begin
        q_ctl.fmt = i2ra_pkg::FMT_OCT;
      end
      i2ra_pkg::CMD_HEXL, i2ra_pkg::CMD_HEXU: begin
        q_ctl.fmt   = i2ra_pkg::FMT_HEX;
        q_ctl.upper = (s_tuser == i2ra_pkg::CMD_HEXU);
      end
      default: begin
        q_ctl.fmt = i2ra_pkg::FMT_DEC;
      end
    endcase
    q_ctl.neg = neg;
  end

  // Most negative value wraps to itself, which reads as 2^(W-1) unsigned
  assign q_mag = neg ? (~operand + 1'b1) : operand;

endmodule

[rtl/i2ra_queue.sv]
// i2ra_queue: short first-in first-out queue between the front and back
// parts. Generic payload width; depends on i2ra_pkg for the default depth.
`timescale 1ns / 1ps

module i2ra_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = i2ra_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             not_empty,
  output logic             full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;

  assign not_empty = (fill != '0);
  assign full      = (fill == CW'(DEPTH));
  assign head_data = slots[rd_ptr];

  // Payload store
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

[rtl/i2ra_back.sv]
// i2ra_back: digit extraction (double dabble for decimal, nibble or 3-bit
// splitting otherwise) into the digit store, then character emission
// through an output register. Depends on i2ra_pkg.
`timescale 1ns / 1ps

module i2ra_back #(
  parameter int VALUE_WIDTH     = i2ra_pkg::DEF_VALUE_WIDTH,
  parameter int MAX_DIGIT_SLOTS = i2ra_pkg::DEF_MAX_DIGIT_SLOTS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  input  i2ra_pkg::item_ctl_t     q_ctl,
  input  logic [VALUE_WIDTH-1:0]  q_mag,
  output logic                    q_pop,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [15:0]             m_tdata,   // char_code [7:0], full_length [12:8]
  output logic [0:0]              m_tuser,   // char_valid [0]
  output logic                    m_tlast
);

  // Decimal digits needed for VALUE_WIDTH bits
  localparam int DEC_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int XW         = 4 * DEC_DIGITS;
  localparam int DAB_CYCLES = (VALUE_WIDTH + 3) / 4;
  localparam int DAB_BITS   = DAB_CYCLES * 4;
  localparam int AW         = XW + DAB_BITS;
  localparam int DCW        = (DAB_CYCLES > 1) ? $clog2(DAB_CYCLES) : 1;
  localparam int CW         = $clog2(MAX_DIGIT_SLOTS + 1);
  localparam int IW         = $clog2(MAX_DIGIT_SLOTS);

  i2ra_pkg::back_state_t state, state_next;

  // Item registers
  i2ra_pkg::fmt_t fmt;
  logic           upper;
  logic           neg;
  logic [7:0]     budget;
  logic [AW-1:0]  dab_acc;
  logic [DCW-1:0] dab_cnt;
  logic [XW-1:0]  work;
  logic [CW-1:0]  digit_count;
  logic [CW-1:0]  emit_left;
  logic [IW-1:0]  pos;
  logic           nul_due;
  logic [4:0]     full_len;
  logic [3:0]     digit_store [MAX_DIGIT_SLOTS];

  // Output register
  logic       out_valid;
  logic [7:0] out_code;
  logic       out_char_valid;
  logic       out_last;
  logic [4:0] out_len;

  // Combinational helpers
  logic [AW-1:0] dab_next;
  logic          dab_done;
  logic [XW-1:0] work_shifted;
  logic [3:0]    split_digit;
  logic [CW-1:0] count_new;
  logic          split_done;
  logic [7:0]    budget_eff;
  logic [7:0]    count_wide;
  logic [CW-1:0] ndig;
  logic          nul_new;
  logic          load;
  logic          emit;
  logic [7:0]    emit_code;
  logic          emit_valid;
  logic          emit_last;

  // Four shift-and-add-3 steps on {bcd, binary}
  function automatic logic [AW-1:0] dabble4(input logic [AW-1:0] acc);
    logic [AW-1:0] a;
    a = acc;
    for (int s = 0; s < 4; s++) begin
      for (int d = 0; d < DEC_DIGITS; d++) begin
        if (a[DAB_BITS + 4*d +: 4] >= 4'd5) begin
          a[DAB_BITS + 4*d +: 4] = a[DAB_BITS + 4*d +: 4] + 4'd3;
        end
      end
      a = a << 1;
    end
    return a;
  endfunction

  assign dab_next = dabble4(dab_acc);
  assign dab_done = (dab_cnt == DCW'(DAB_CYCLES - 1));

  // Digit splitting, least significant first
  assign work_shifted = (fmt == i2ra_pkg::FMT_OCT) ? (work >> 3) : (work >> 4);
  assign split_digit  = (fmt == i2ra_pkg::FMT_OCT) ? {1'b0, work[2:0]} : work[3:0];
  assign count_new    = digit_count + 1'b1;
  assign split_done   = (work_shifted == '0) || (count_new == CW'(MAX_DIGIT_SLOTS));

  // Emission plan, settled when splitting ends
  assign budget_eff = budget - 8'(neg);
  assign count_wide = 8'(count_new);
  assign ndig       = (count_wide < budget_eff) ? count_new : CW'(budget_eff);
  assign nul_new    = (count_wide < budget_eff);

  assign load = !out_valid || m_tready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      i2ra_pkg::ST_IDLE: begin
        if (q_valid) begin
          state_next = (q_ctl.fmt == i2ra_pkg::FMT_DEC) ? i2ra_pkg::ST_DABBLE
                                                        : i2ra_pkg::ST_SPLIT;
        end
      end
      i2ra_pkg::ST_DABBLE: begin
        if (dab_done) begin
          state_next = i2ra_pkg::ST_SPLIT;
        end
      end
      i2ra_pkg::ST_SPLIT: begin
        if (split_done) begin
          if (budget == 8'd0) begin
            state_next = i2ra_pkg::ST_EMPTY;
          end else if (neg) begin
            state_next = i2ra_pkg::ST_SIGN;
          end else begin
            state_next = i2ra_pkg::ST_DIGITS;
          end
        end
      end
      i2ra_pkg::ST_SIGN: begin
        if (load) begin
          if (emit_left != '0) begin
            state_next = i2ra_pkg::ST_DIGITS;
          end else if (nul_due) begin
            state_next = i2ra_pkg::ST_NUL;
          end else begin
            state_next = i2ra_pkg::ST_IDLE;
          end
        end
      end
      i2ra_pkg::ST_DIGITS: begin
        if (load && emit_left == CW'(1)) begin
          state_next = nul_due ? i2ra_pkg::ST_NUL : i2ra_pkg::ST_IDLE;
        end
      end
      i2ra_pkg::ST_NUL, i2ra_pkg::ST_EMPTY: begin
        if (load) begin
          state_next = i2ra_pkg::ST_IDLE;
        end
      end
      default: state_next = i2ra_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    q_pop      = 1'b0;
    emit       = 1'b0;
    emit_code  = i2ra_pkg::CH_NUL;
    emit_valid = 1'b1;
    emit_last  = 1'b0;
    unique case (state)
      i2ra_pkg::ST_IDLE: begin
        q_pop = q_valid;
      end
      i2ra_pkg::ST_SIGN: begin
        emit      = 1'b1;
        emit_code = i2ra_pkg::CH_MINUS;
        emit_last = (emit_left == '0) && !nul_due;
      end
      i2ra_pkg::ST_DIGITS: begin
        emit      = 1'b1;
        emit_code = i2ra_pkg::digit_char(digit_store[pos], upper);
        emit_last = (emit_left == CW'(1)) && !nul_due;
      end
      i2ra_pkg::ST_NUL: begin
        emit      = 1'b1;
        emit_last = 1'b1;
      end
      i2ra_pkg::ST_EMPTY: begin
        emit       = 1'b1;
        emit_valid = 1'b0;
        emit_last  = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= i2ra_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Item datapath
  always_ff @(posedge clk) begin
    case (state)
      i2ra_pkg::ST_IDLE: begin
        if (q_valid) begin
          fmt         <= q_ctl.fmt;
          upper       <= q_ctl.upper;
          neg         <= q_ctl.neg;
          budget      <= q_ctl.budget;
          dab_acc     <= {{XW{1'b0}}, DAB_BITS'(q_mag)};
          dab_cnt     <= '0;
          work        <= XW'(q_mag);
          digit_count <= '0;
        end
      end
      i2ra_pkg::ST_DABBLE: begin
        dab_acc <= dab_next;
        dab_cnt <= dab_cnt + 1'b1;
        if (dab_done) begin
          work <= dab_next[AW-1 -: XW];
        end
      end
      i2ra_pkg::ST_SPLIT: begin
        digit_store[digit_count[IW-1:0]] <= split_digit;
        work        <= work_shifted;
        digit_count <= count_new;
        if (split_done) begin
          emit_left <= ndig;
          nul_due   <= nul_new;
          pos       <= IW'(count_new - 1'b1);
          full_len  <= 5'(count_new + CW'(neg));
        end
      end
      i2ra_pkg::ST_DIGITS: begin
        if (load) begin
          emit_left <= emit_left - 1'b1;
          pos       <= pos - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= emit;
    end
  end

  // Output register: payload
  always_ff @(posedge clk) begin
    if (load && emit) begin
      out_code       <= emit_code;
      out_char_valid <= emit_valid;
      out_last       <= emit_last;
      out_len        <= full_len;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_len, out_code};
  assign m_tuser  = out_char_valid;
  assign m_tlast  = out_last;

endmodule

[dv/integer_to_radix_ascii_test.sv]
// integer_to_radix_ascii_test: self-checking testbench for the integer to
// radix ASCII converter, with a scoreboard class that predicts every character.
// Depends on i2ra_pkg and integer_to_radix_ascii in rtl/.
`timescale 1ns / 1ps

module integer_to_radix_ascii_test;

  localparam int DIGIT_SLOTS  = 24;
  localparam int RESULT_CAP   = 23;
  localparam int RANDOM_OPS   = 420;
  localparam int STEADY_FROM  = 360;
  localparam int HOLD_AT      = 40;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE       = 100;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int REPORT_LIMIT = 10;

  // One character transfer on the output stream
  typedef struct packed {
    logic [7:0] code;
    logic       written;
    logic       last;
    logic [4:0] length;
  } char_xfer_t;

  // Predicts the characters of each accepted operand and checks them in order
  class char_scoreboard;
    char_xfer_t expected_chars[$];
    int mismatches;
    int operands;
    int truncated;
    int empties;
    int checked;

    function new();
      mismatches = 0;
      operands   = 0;
      truncated  = 0;
      empties    = 0;
      checked    = 0;
    endfunction

    function void note_operand(logic [2:0] cmd, logic [63:0] value, logic [7:0] budget);
      char_xfer_t  line [RESULT_CAP];
      logic [3:0]  digits [DIGIT_SLOTS];
      logic [63:0] mag;
      logic [63:0] radix;
      logic [3:0]  d;
      logic [7:0]  code;
      logic        neg;
      int          ndig;
      int          room;
      int          k;
      int          full_len;
      radix = (cmd == i2ra_pkg::CMD_OCT) ? 64'd8 :
              (cmd == i2ra_pkg::CMD_HEXL || cmd == i2ra_pkg::CMD_HEXU) ? 64'd16 : 64'd10;
      neg = (cmd == i2ra_pkg::CMD_SDEC) && value[63];
      // most negative value wraps to 2^63, which is the right magnitude
      mag = neg ? -value : value;
      ndig = 0;
      do begin
        digits[ndig] = 4'(mag % radix);
        mag = mag / radix;
        ndig++;
      end while (mag != 0 && ndig < DIGIT_SLOTS);
      full_len = ndig + (neg ? 1 : 0);
      k = 0;
      operands++;
      if (budget == 8'd0) begin
        // empty budget: one transfer, nothing written, not even the sign
        line[0] = '{code: i2ra_pkg::CH_NUL, written: 1'b0, last: 1'b0,
                    length: 5'(full_len)};
        k = 1;
        empties++;
      end else begin
        room = budget;
        if (neg) begin
          line[k] = '{code: i2ra_pkg::CH_MINUS, written: 1'b1, last: 1'b0,
                      length: 5'(full_len)};
          k++;
          room--;
        end
        for (int i = 0; i < ndig && i < room && k < RESULT_CAP; i++) begin
          d = digits[ndig - 1 - i];
          if (d < 4'd10) code = i2ra_pkg::CH_ZERO + 8'(d);
          else code = ((cmd == i2ra_pkg::CMD_HEXU) ? i2ra_pkg::CH_UPPER_A
                                                   : i2ra_pkg::CH_LOWER_A)
                      + 8'(d) - 8'd10;
          line[k] = '{code: code, written: 1'b1, last: 1'b0, length: 5'(full_len)};
          k++;
        end
        // terminator only when a slot is left after the digits
        if (ndig < room && k < RESULT_CAP) begin
          line[k] = '{code: i2ra_pkg::CH_NUL, written: 1'b1, last: 1'b0,
                      length: 5'(full_len)};
          k++;
        end else begin
          truncated++;
        end
      end
      line[k - 1].last = 1'b1;
      for (int i = 0; i < k; i++) expected_chars.push_back(line[i]);
    endfunction

    function void check_char(char_xfer_t got);
      char_xfer_t want;
      checked++;
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("[%0t] unexpected character: code %h written %b last %b length %0d",
                   $time, got.code, got.written, got.last, got.length);
        return;
      end
      want = expected_chars.pop_front();
      if (got.code !== want.code || got.written !== want.written ||
          got.last !== want.last || got.length !== want.length) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("[%0t] mismatch: expected %h/%b/%b/%0d, got %h/%b/%b/%0d",
                   $time, want.code, want.written, want.last, want.length,
                   got.code, got.written, got.last, got.length);
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    function int failures();
      return mismatches + expected_chars.size();
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata  = '0;   // value [63:0], max_chars [71:64]
  logic [2:0]  s_tuser  = '0;   // command [2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;         // char_code [7:0], full_length [12:8], zero pad
  logic [0:0]  m_tuser;         // char_valid [0]
  logic        m_tlast;

  char_scoreboard sb;
  logic steady        = 1'b0;
  logic long_hold_req = 1'b0;
  logic hold_active   = 1'b0;
  int   sent          = 0;
  int   held_cycles   = 0;
  int   cycle_count   = 0;

  integer_to_radix_ascii uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count++;
    $display("Timeout after %0d cycles", cycle_count);
    $display("Test completed with failures");
    $finish;
  end

  // Transfers seen on both streams
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      sb.note_operand(s_tuser, s_tdata[63:0], s_tdata[71:64]);
    if (!rst && m_tvalid && m_tready)
      sb.check_char('{code: m_tdata[7:0], written: m_tuser[0], last: m_tlast,
                      length: m_tdata[12:8]});
  end

  // Receiver: random stall bursts, one long hold-off, always ready at the end
  initial begin
    @(negedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_active   = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        held_cycles += LONG_HOLD;
        hold_active = 1'b0;
      end else if (!steady && $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat (steady ? 1 : $urandom_range(1, 24)) @(negedge clk);
      end
    end
  end

  // Offer one operand, with an optional idle burst first; returns on a negedge
  task automatic send_operand(input logic [2:0] cmd, input logic [63:0] value,
                              input logic [7:0] budget);
    int gap;
    gap = (!steady && !hold_active && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {budget, value};
    s_tuser  <= cmd;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    sent++;
  endtask

  function automatic logic [63:0] rand_operand();
    logic [63:0] full;
    full = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return full;
      1: return full >> $urandom_range(0, 63);
      2: return 64'($urandom_range(0, 1000));
      3: return -64'($urandom_range(1, 1000));
      4: return (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
      default: begin
        case ($urandom_range(0, 3))
          0: return 64'h0;
          1: return 64'hFFFF_FFFF_FFFF_FFFF;
          2: return 64'h8000_0000_0000_0000;
          default: return 64'h7FFF_FFFF_FFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  function automatic logic [2:0] rand_command();
    logic [2:0] known [5];
    known = '{i2ra_pkg::CMD_UDEC, i2ra_pkg::CMD_SDEC, i2ra_pkg::CMD_OCT,
              i2ra_pkg::CMD_HEXL, i2ra_pkg::CMD_HEXU};
    // codes above the hex commands fall back to unsigned decimal
    if ($urandom_range(0, 15) == 0) return i2ra_pkg::CMD_HEXU + 3'($urandom_range(1, 3));
    return known[$urandom_range(0, 4)];
  endfunction

  function automatic logic [7:0] rand_budget();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 25));
  endfunction

  // Main sequence
  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: extremes, every command, sign and budget corner cases
    send_operand(i2ra_pkg::CMD_UDEC, 64'h0, 8'd24);
    send_operand(i2ra_pkg::CMD_UDEC, 64'hFFFF_FFFF_FFFF_FFFF, 8'd255);
    send_operand(i2ra_pkg::CMD_UDEC, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0);
    send_operand(i2ra_pkg::CMD_SDEC, 64'h8000_0000_0000_0000, 8'd24);
    send_operand(i2ra_pkg::CMD_SDEC, 64'h7FFF_FFFF_FFFF_FFFF, 8'd24);
    send_operand(i2ra_pkg::CMD_SDEC, 64'hFFFF_FFFF_FFFF_FFFF, 8'd24);
    send_operand(i2ra_pkg::CMD_SDEC, -64'd42, 8'd1);
    send_operand(i2ra_pkg::CMD_SDEC, -64'd42, 8'd0);
    send_operand(i2ra_pkg::CMD_SDEC, -64'd42, 8'd3);
    send_operand(i2ra_pkg::CMD_SDEC, 64'd42, 8'd3);
    send_operand(i2ra_pkg::CMD_OCT, 64'hFFFF_FFFF_FFFF_FFFF, 8'd255);
    send_operand(i2ra_pkg::CMD_OCT, 64'h0, 8'd1);
    send_operand(i2ra_pkg::CMD_HEXL, 64'h0123_4567_89AB_CDEF, 8'd24);
    send_operand(i2ra_pkg::CMD_HEXU, 64'hFEDC_BA98_7654_3210, 8'd24);
    send_operand(i2ra_pkg::CMD_HEXL, 64'hFFFF_FFFF_FFFF_FFFF, 8'd16);
    send_operand(i2ra_pkg::CMD_HEXU, 64'hFFFF_FFFF_FFFF_FFFF, 8'd17);
    send_operand(i2ra_pkg::CMD_UDEC, 64'd12345, 8'd3);
    send_operand(i2ra_pkg::CMD_UDEC, 64'd12345, 8'd5);
    send_operand(i2ra_pkg::CMD_UDEC, 64'd12345, 8'd6);
    send_operand(i2ra_pkg::CMD_HEXU + 3'd1, 64'h8000_0000_0000_0001, 8'd24);
    send_operand(i2ra_pkg::CMD_HEXU + 3'd2, 64'hFFFF_FFFF_FFFF_FFFF, 8'd21);
    send_operand(i2ra_pkg::CMD_HEXU + 3'd3, 64'hDEAD_BEEF_CAFE_F00D, 8'd255);

    // random operands; a long receiver hold early on, no idling at the end
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n == HOLD_AT) long_hold_req = 1'b1;
      if (n == STEADY_FROM) steady = 1'b1;
      send_operand(rand_command(), rand_operand(), rand_budget());
    end
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Converted %0d operands (%0d cut short, %0d empty budget), %0d chars checked",
             sb.operands, sb.truncated, sb.empties, sb.checked);
    $display("Receiver held off %0d cycles under input; last %0d operands without idling",
             held_cycles, RANDOM_OPS - STEADY_FROM);
    if (sb.failures() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d characters still expected", sb.mismatches, sb.pending());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[integer_to_radix_ascii.f]
rtl/i2ra_pkg.sv
rtl/i2ra_front.sv
rtl/i2ra_queue.sv
rtl/i2ra_back.sv
rtl/integer_to_radix_ascii.sv
dv/integer_to_radix_ascii_test.sv
